### hw/rtl/utf8tok_pkg.sv
package utf8tok_pkg;

  localparam int MaxResults = 6;
  localparam int CountW     = 3;

  // Result kinds as carried on the output tuser bit
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
  } result_t;

  // One code point handed to the word splitter; a separator when word is low
  typedef struct packed {
    logic       valid;
    logic       word;
    logic [7:0] cp;
  } cp_event_t;

  // Multi-byte sequence in progress
  typedef struct packed {
    logic [7:0]  lead;
    logic [1:0]  need;
    logic [1:0]  seen;
    logic [20:0] pcp;
  } pend_t;

  function automatic logic is_word8(input logic [7:0] cp);
    return (cp >= 8'h30 && cp <= 8'h39) ||
           (cp >= 8'h41 && cp <= 8'h5A) ||
           (cp >= 8'h61 && cp <= 8'h7A) ||
           (cp >= 8'hC0 && cp != 8'hD7 && cp != 8'hF7);
  endfunction

  function automatic logic [7:0] lower8(input logic [7:0] cp);
    logic up;
    up = (cp >= 8'h41 && cp <= 8'h5A) ||
         (cp >= 8'hC0 && cp <= 8'hDE && cp != 8'hD7);
    return up ? cp + 8'h20 : cp;
  endfunction

endpackage

### hw/rtl/utf8_word_tokenizer.sv
// UTF-8 word tokenizer.
// Input stream (s_*): one text byte per transaction in s_tdata; s_tlast marks
// the final byte of a text and flushes any pending sequence and open word.
// Output stream (m_*): one result per transaction. m_tuser low carries a
// lowercased UTF-8 token byte in m_tdata; m_tuser high marks the end of the
// current token with m_tdata zero. m_tlast flags the final result caused by
// one input byte. A byte may cause no result at all, or up to six.
// Each accepted byte is decoded, classified and expanded into its whole
// result list in the cycle it is taken; the list lands in a six-entry result
// buffer and drains through a single output register, one result per cycle
// while m_tready is high. The results of a byte are registered first in the
// buffer, then in the output register. Throughput: one byte per cycle while
// each byte yields at most one result and the receiver does not stall;
// otherwise the input side waits until the buffer hands over its last entry.
// A new byte is taken as soon as the buffer is empty or hands over its last
// entry, even while the output register still holds a result.
// If the receiver stalls, the output register holds its result, the buffer
// holds the rest and s_tready drops once the buffer cannot be refilled.
// Reset (rst, synchronous) drops any pending sequence, closes no word and
// empties the buffer and output register.
module utf8_word_tokenizer
  import utf8tok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] kind
  output logic       m_tlast    // last_of_run
);

  pend_t       pend, pend_next;
  logic        inside_token, inside_token_next;
  result_t     rbuf [MaxResults];
  result_t     list [MaxResults];
  logic [CountW-1:0] rcount, rcount_next, list_count;
  cp_event_t   ev [6];
  logic        pending, cont, xfer, accept;
  logic [1:0]  seen_inc;
  logic [20:0] pcp_inc;
  pend_t       s1;
  logic        ins;
  logic [7:0]  lc;

  // Handshake: refill the buffer when it is empty or about to be
  assign xfer     = (rcount != '0) && (!m_tvalid || m_tready);
  assign s_tready = (rcount == '0) || ((rcount == CountW'(1)) && xfer);
  assign accept   = s_tvalid && s_tready;

  assign pending  = pend.need != 2'd0;
  assign cont     = s_tdata[7:6] == 2'b10;
  assign seen_inc = pend.seen + 2'd1;
  assign pcp_inc  = {pend.pcp[14:0], s_tdata[5:0]};

  // Decode: turn the byte into an ordered list of code point events
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ev[k] = '0;
    end
    s1 = pend;

    // Bad continuation: lead stands alone, taken continuations separate
    if (pending && !cont) begin
      ev[0] = '{valid: 1'b1, word: is_word8(pend.lead), cp: pend.lead};
      ev[1] = '{valid: pend.seen != 2'd0, word: 1'b0, cp: 8'h00};
    end

    if (pending && cont) begin
      if (seen_inc >= pend.need) begin
        ev[2] = '{valid: 1'b1,
                  word: (pcp_inc[20:8] == '0) && is_word8(pcp_inc[7:0]),
                  cp: pcp_inc[7:0]};
        s1 = '0;
      end else begin
        s1.seen = seen_inc;
        s1.pcp  = pcp_inc;
      end
    end else begin
      s1 = '0;
      if ((s_tdata & 8'hE0) == 8'hC0) begin
        s1 = '{lead: s_tdata, need: 2'd1, seen: 2'd0, pcp: {16'h0, s_tdata[4:0]}};
      end else if ((s_tdata & 8'hF0) == 8'hE0) begin
        s1 = '{lead: s_tdata, need: 2'd2, seen: 2'd0, pcp: {17'h0, s_tdata[3:0]}};
      end else if ((s_tdata & 8'hF8) == 8'hF0) begin
        s1 = '{lead: s_tdata, need: 2'd3, seen: 2'd0, pcp: {18'h0, s_tdata[2:0]}};
      end else begin
        // ASCII, stray continuation or invalid lead: a code point of its own
        ev[2] = '{valid: 1'b1, word: is_word8(s_tdata), cp: s_tdata};
      end
    end

    // End of text: flush a truncated sequence, then close the word
    pend_next = s1;
    if (s_tlast) begin
      if (s1.need != 2'd0) begin
        ev[3] = '{valid: 1'b1, word: is_word8(s1.lead), cp: s1.lead};
        ev[4] = '{valid: s1.seen != 2'd0, word: 1'b0, cp: 8'h00};
      end
      ev[5] = '{valid: 1'b1, word: 1'b0, cp: 8'h00};
      pend_next = '0;
    end
  end

  // Expand events into result items: word bytes or a token end
  always_comb begin
    for (int k = 0; k < MaxResults; k++) begin
      list[k] = '0;
    end
    list_count = '0;
    ins        = inside_token;
    lc         = '0;
    for (int k = 0; k < 6; k++) begin
      if (ev[k].valid) begin
        if (ev[k].word) begin
          lc = lower8(ev[k].cp);
          if (!lc[7]) begin
            list[list_count] = '{data: lc, kind: KIND_BYTE};
            list_count = list_count + CountW'(1);
          end else begin
            list[list_count] = '{data: {6'b110000, lc[7:6]}, kind: KIND_BYTE};
            list[list_count + CountW'(1)] = '{data: {2'b10, lc[5:0]}, kind: KIND_BYTE};
            list_count = list_count + CountW'(2);
          end
          ins = 1'b1;
        end else if (ins) begin
          list[list_count] = '{data: 8'h00, kind: KIND_END};
          list_count = list_count + CountW'(1);
          ins = 1'b0;
        end
      end
    end
    inside_token_next = ins;
  end

  always_comb begin
    if (accept) begin
      rcount_next = list_count;
    end else if (xfer) begin
      rcount_next = rcount - CountW'(1);
    end else begin
      rcount_next = rcount;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= '0;
      inside_token <= 1'b0;
      rcount       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        pend         <= pend_next;
        inside_token <= inside_token_next;
      end
      rcount <= rcount_next;
      if (xfer) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result buffer: load a whole list, advance one entry per hand-over
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MaxResults; k++) begin
        rbuf[k] <= list[k];
      end
    end else if (xfer) begin
      for (int k = 0; k < MaxResults - 1; k++) begin
        rbuf[k] <= rbuf[k+1];
      end
    end
    if (xfer) begin
      m_tdata <= rbuf[0].data;
      m_tuser <= rbuf[0].kind;
      m_tlast <= rcount == CountW'(1);
    end
  end

endmodule

### hw/rtl/utf8tok_checker.sv
module utf8tok_checker
  import utf8tok_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // A token end carries no byte
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_END) |-> (m_tdata == 8'h00))
    else $error("token end with non-zero data");

  // A two-byte lead is always followed by its continuation from the same byte
  a_lead_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE && m_tdata[7:6] == 2'b11) |-> !m_tlast)
    else $error("lead byte closes a run");

  // Nothing is offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                 $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind utf8_word_tokenizer utf8tok_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### verif/utf8_word_tokenizer_checker.sv
`timescale 1ns / 1ps

// Watch both streams, predict the lowercased token stream and compare each
// output transaction with the oldest prediction.
module utf8_word_tokenizer_checker
  import utf8tok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_text
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic       m_tuser,   // [0] kind
  input  logic       m_tlast,   // last_of_run
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } token_item_t;

  localparam logic [7:0] ContByte = 8'h80;

  token_item_t token_q[$];    // predicted results still to arrive
  token_item_t byte_results[$];
  pend_t       seq;
  logic        in_word;

  function automatic void emit(input logic [7:0] data, input logic kind);
    token_item_t item;
    item = '{data, kind, 1'b0};
    if (byte_results.size() < MaxResults) byte_results.insert(byte_results.size(), item);
  endfunction

  function automatic void close_word();
    if (in_word) begin
      emit(8'h00, KIND_END);
      in_word = 1'b0;
    end
  endfunction

  function automatic void take_code_point(input logic [20:0] cp);
    logic word_char;
    logic [20:0] low;
    word_char = (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
                (cp >= 21'h61 && cp <= 21'h7A) ||
                (cp >= 21'hC0 && cp <= 21'hFF && cp != 21'hD7 && cp != 21'hF7);
    if (!word_char) begin
      close_word();
    end else begin
      low = cp;
      if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7))
        low = cp + 21'h20;
      if (low < 21'h80) begin
        emit(low[7:0], KIND_BYTE);
      end else begin
        emit({6'b110000, low[7:6]}, KIND_BYTE);
        emit({2'b10, low[5:0]}, KIND_BYTE);
      end
      in_word = 1'b1;
    end
  endfunction

  // Lead stands alone, each continuation already taken acts as a separator
  function automatic void abandon_sequence();
    logic [1:0] taken;
    taken = seq.seen;
    take_code_point({13'b0, seq.lead});
    for (int k = 0; k < taken; k++) take_code_point({13'b0, ContByte});
    seq = '0;
  endfunction

  function automatic void start_char(input logic [7:0] b);
    if (!b[7]) begin
      take_code_point({13'b0, b});
    end else if (b[7:5] == 3'b110) begin
      seq = '{lead: b, need: 2'd1, seen: 2'd0, pcp: {16'b0, b[4:0]}};
    end else if (b[7:4] == 4'b1110) begin
      seq = '{lead: b, need: 2'd2, seen: 2'd0, pcp: {17'b0, b[3:0]}};
    end else if (b[7:3] == 5'b11110) begin
      seq = '{lead: b, need: 2'd3, seen: 2'd0, pcp: {18'b0, b[2:0]}};
    end else begin
      take_code_point({13'b0, b});
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic eot);
    logic [20:0] cp;
    byte_results.delete();
    if (seq.need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq.pcp  = {seq.pcp[14:0], b[5:0]};
        seq.seen = seq.seen + 2'd1;
        if (seq.seen >= seq.need) begin
          cp  = seq.pcp;
          seq = '0;
          take_code_point(cp);
        end
      end else begin
        abandon_sequence();
        start_char(b);
      end
    end else begin
      start_char(b);
    end
    if (eot) begin
      if (seq.need != 2'd0) abandon_sequence();
      close_word();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) token_q.insert(token_q.size(), byte_results[i]);
  endfunction

  always @(posedge clk) begin
    token_item_t want;
    if (rst) begin
      token_q.delete();
      seq        = '0;
      in_word    = 1'b0;
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          $error("unexpected result: out_byte %02h kind %0b last_of_run %0b",
                 m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte mismatch: expected %02h, got %02h", want.data, m_tdata);
            mismatches++;
          end
          if (m_tuser !== want.kind) begin
            $error("kind mismatch: expected %0b, got %0b", want.kind, m_tuser);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run mismatch: expected %0b, got %0b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
    outstanding = token_q.size();
  end

endmodule

### verif/utf8_word_tokenizer_tb.sv
`timescale 1ns / 1ps

// Drive UTF-8 text into the tokenizer, pace the result stream and give the
// verdict; prediction and comparison live in the checker.
module utf8_word_tokenizer_tb;

  localparam int RandomItems = 132;
  localparam int QuietLimit  = 1000;  // cycles without any transaction
  localparam int LongHold    = 120;   // receiver hold-off, in cycles
  localparam int DrainCycles = 8;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;
  int         mismatches;
  int         outstanding;

  logic [7:0] char_bytes[$];
  logic       tx_eager;
  int         items_sent;

  // {end_of_text, in_byte}: letters and digits at their extremes, a NUL
  // separator, Latin-1 letters and the excluded multiplication sign, an
  // overlong 'A', a stray invalid lead byte and a stray continuation, a bad
  // continuation, a four-byte separator, and truncation at end of text with
  // the six-result worst case last.
  logic [8:0] directed [28] = '{
    9'h041, 9'h07A, 9'h030, 9'h039, 9'h000, 9'h0C3, 9'h089, 9'h0C3, 9'h097,
    9'h0C3, 9'h0BF, 9'h0C1, 9'h081, 9'h0FF, 9'h080, 9'h0E2, 9'h082, 9'h078,
    9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h05A, 9'h1C3, 9'h0F0, 9'h090, 9'h080,
    9'h1C3
  };

  utf8_word_tokenizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8_word_tokenizer_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one byte after a random gap and hold it until the transaction.
  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
    if (items_sent % 25 == 0) tx_eager = ($urandom_range(0, 3) == 0);
  endtask

  // Append one byte to the character being built
  function automatic void add_byte(input logic [7:0] b);
    char_bytes.insert(char_bytes.size(), b);
  endfunction

  // Encode a code point with a chosen length; a length above the minimum
  // gives an overlong form.
  function automatic void encode_char(input logic [20:0] cp, input int len);
    char_bytes.delete();
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Build one random character: mostly well-formed text, then overlong
  // forms, truncated sequences and raw noise.
  function automatic void random_char();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      encode_char(21'($urandom_range(0, 127)), 1);
    end else if (pick < 45) begin
      case ($urandom_range(0, 2))
        0:       encode_char(21'($urandom_range(8'h41, 8'h5A)), 1);
        1:       encode_char(21'($urandom_range(8'h61, 8'h7A)), 1);
        default: encode_char(21'($urandom_range(8'h30, 8'h39)), 1);
      endcase
    end else if (pick < 65) begin
      encode_char(21'($urandom_range(8'h80, 8'hFF)), 2);
    end else if (pick < 73) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       encode_char(21'($urandom_range(21'h100, 21'h7FF)), 2);
        3:       encode_char(21'($urandom_range(21'h800, 21'hFFFF)), 3);
        default: encode_char(21'($urandom_range(21'h10000, 21'h1FFFFF)), 4);
      endcase
    end else if (pick < 80) begin
      encode_char(21'($urandom_range(0, 255)), $urandom_range(2, 4));
    end else if (pick < 90) begin
      len = $urandom_range(2, 4);
      encode_char(21'($urandom_range(0, 21'h1FFFFF)), len);
      repeat ($urandom_range(1, len - 1)) void'(char_bytes.pop_back());
    end else begin
      char_bytes.delete();
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Main stimulus: reset, directed text, random text, drain, verdict
  initial begin
    logic eot;
    tx_eager   = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    while (items_sent < $size(directed) + RandomItems) begin
      random_char();
      // end the text now and then, sometimes in mid-sequence
      eot = ($urandom_range(0, 15) == 0);
      foreach (char_bytes[i]) send_byte(char_bytes[i], eot && (i == char_bytes.size() - 1));
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver: random stalls per transaction, eager stretches, and two
  // long hold-offs that fill the result buffer and back-pressure the input.
  initial begin
    int gap;
    int taken;
    logic rx_eager;
    taken    = 0;
    rx_eager = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken == 40 || taken == 130) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else begin
        gap = rx_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
      taken++;
      if (taken % 25 == 0) rx_eager = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: give up once no transaction has moved for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
